### hw/rtl/mbcg_pkg.sv
// mbcg_pkg: shared types and constants of the motion burst capture gate
// payload structs, configuration block, register indexes, gate codes and serial unit requests
// no dependencies
package mbcg_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int MAG_W    = 16;
  localparam int ACC_W    = 32;

  typedef enum logic [1:0] {
    GATE_IDLE     = 2'd0,
    GATE_ARMED    = 2'd1,
    GATE_CAPTURE  = 2'd2,
    GATE_COOLDOWN = 2'd3
  } gate_t;

  // register index, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_EMA_WEIGHT      = 3'd0,
    REG_DEVIATION_FLOOR = 3'd1,
    REG_ONSET_GAIN      = 3'd2,
    REG_OFFSET_GAIN     = 3'd3,
    REG_ONSET_CONFIRM   = 3'd4,
    REG_SETTLE_CONFIRM  = 3'd5,
    REG_CAPTURE_DELAY   = 3'd6,
    REG_COOLDOWN_LIMIT  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] gyro_x;
    logic signed [SAMPLE_W-1:0] gyro_y;
    logic signed [SAMPLE_W-1:0] gyro_z;
    logic                       window_done;
    logic                       restart;
  } in_item_t;

  typedef struct packed {
    logic             accept;
    logic [1:0]       gate_state;
    logic [MAG_W-1:0] magnitude;
  } out_item_t;

  typedef struct packed {
    logic [15:0] ema_weight;
    logic [31:0] deviation_floor;
    logic [7:0]  onset_gain;
    logic [7:0]  offset_gain;
    logic [3:0]  onset_confirm;
    logic [3:0]  settle_confirm;
    logic [7:0]  capture_delay;
    logic [9:0]  cooldown_limit;
  } cfg_t;

  localparam logic [15:0] RST_EMA_WEIGHT      = 16'd1311;
  localparam logic [31:0] RST_DEVIATION_FLOOR = 32'd107374;
  localparam logic [7:0]  RST_ONSET_GAIN      = 8'd64;
  localparam logic [7:0]  RST_OFFSET_GAIN     = 8'd32;
  localparam logic [3:0]  RST_ONSET_CONFIRM   = 4'd3;
  localparam logic [3:0]  RST_SETTLE_CONFIRM  = 4'd5;
  localparam logic [7:0]  RST_CAPTURE_DELAY   = 8'd35;
  localparam logic [9:0]  RST_COOLDOWN_LIMIT  = 10'd200;

  // serial multiplier: 32 x 16 bits, one multiplier bit per cycle
  typedef struct packed {
    logic        go;
    logic        rnd;
    logic [31:0] a;
    logic [15:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] p;
  } mul_rsp_t;

  // serial square root: two radicand bits per cycle
  typedef struct packed {
    logic             go;
    logic [ACC_W-1:0] n;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] root;
  } sqrt_rsp_t;

endpackage

### hw/rtl/mbcg_mul.sv
// mbcg_mul: shift-add multiplier, one multiplier bit per cycle
// optional half-lsb rounding constant preloaded for the averaging step
// depends on mbcg_pkg
module mbcg_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  mbcg_pkg::mul_req_t req,
  output mbcg_pkg::mul_rsp_t rsp
);

  logic [47:0] a_r;
  logic [15:0] b_r;
  logic [47:0] acc_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      a_r   <= {16'd0, req.a};
      b_r   <= req.b;
      acc_r <= req.rnd ? 48'd32768 : 48'd0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= {a_r[46:0], 1'b0};
      b_r <= {1'b0, b_r[15:1]};
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

### hw/rtl/mbcg_isqrt.sv
// mbcg_isqrt: restoring digit-by-digit floor square root of a 32 bit value
// one root bit per cycle
// depends on mbcg_pkg
module mbcg_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  mbcg_pkg::sqrt_req_t req,
  output mbcg_pkg::sqrt_rsp_t rsp
);

  logic [mbcg_pkg::ACC_W-1:0] n_r;
  logic [16:0]                rem_r;
  logic [mbcg_pkg::MAG_W-1:0] root_r;
  logic [3:0]                 cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [18:0] rem_sh;
  logic [18:0] trial;
  logic [18:0] diff;
  logic        ge;

  assign rem_sh = {rem_r, n_r[mbcg_pkg::ACC_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign diff   = rem_sh - trial;
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      n_r    <= req.n;
      rem_r  <= 17'd0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r <= {n_r[mbcg_pkg::ACC_W-3:0], 2'b00};
      if (ge) begin
        rem_r  <= diff[16:0];
        root_r <= {root_r[mbcg_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[16:0];
        root_r <= {root_r[mbcg_pkg::MAG_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

### hw/rtl/mbcg_seq.sv
// mbcg_seq: per-sample sequencer and gate state (baseline, deviation, counters)
// drives the shared serial multiplier and the serial square root
// depends on mbcg_pkg, mbcg_mul, mbcg_isqrt
module mbcg_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  mbcg_pkg::cfg_t      cfg,
  input  logic                in_valid,
  input  mbcg_pkg::in_item_t  in_item,
  output logic                ready,
  input  logic                out_free,
  output logic                res_valid,
  output mbcg_pkg::out_item_t res
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_SQ     = 11'b00000000010,
    S_ROOT   = 11'b00000000100,
    S_BEMA   = 11'b00000001000,
    S_AD     = 11'b00000010000,
    S_DSTART = 11'b00000100000,
    S_DEMA   = 11'b00001000000,
    S_FLOOR  = 11'b00010000000,
    S_GAIN   = 11'b00100000000,
    S_DECIDE = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } seq_state_t;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    logic [15:0] u;
    begin
      u = v;
      abs16 = v[15] ? (~u + 16'd1) : u;
    end
  endfunction

  function automatic logic [31:0] ema_apply(input logic [31:0] x, input logic [31:0] step,
                                            input logic up);
    logic [32:0] s;
    begin
      s = {1'b0, x} + {1'b0, step};
      if (up) begin
        ema_apply = s[32] ? 32'hFFFF_FFFF : s[31:0];
      end else begin
        ema_apply = (step >= x) ? 32'd0 : x - step;
      end
    end
  endfunction

  seq_state_t          state_r, state_nxt;
  mbcg_pkg::gate_t     gate_r, gate_nxt;
  logic [31:0]         base_r, base_nxt;
  logic [31:0]         dev_r, dev_nxt;
  logic                seeded_r, seeded_nxt;
  logic [7:0]          cc_r, cc_nxt;
  logic [9:0]          cool_r, cool_nxt;
  mbcg_pkg::in_item_t  item_r, item_nxt;
  logic [1:0]          axis_r, axis_nxt;
  logic [31:0]         sum_r, sum_nxt;
  logic [15:0]         mag_r, mag_nxt;
  logic                up_r, up_nxt;
  logic [31:0]         ad_r, ad_nxt;
  logic [40:0]         thr_r, thr_nxt;
  mbcg_pkg::out_item_t res_r, res_nxt;
  logic                mgo_r, mgo_nxt;
  logic                mrnd_r, mrnd_nxt;
  logic [31:0]         ma_r, ma_nxt;
  logic [15:0]         mb_r, mb_nxt;
  logic                sgo_r, sgo_nxt;

  mbcg_pkg::mul_req_t  mul_req;
  mbcg_pkg::mul_rsp_t  mul_rsp;
  mbcg_pkg::sqrt_req_t sqrt_req;
  mbcg_pkg::sqrt_rsp_t sqrt_rsp;

  logic [31:0] mq;
  logic [31:0] mq_root;
  logic [31:0] step;
  logic [40:0] lhs;
  logic [7:0]  cc_inc;
  logic [9:0]  cool_inc;

  assign mq       = {mag_r, {mbcg_pkg::FRAC_W{1'b0}}};
  assign mq_root  = {sqrt_rsp.root, {mbcg_pkg::FRAC_W{1'b0}}};
  assign step     = mul_rsp.p[47:16];
  assign lhs      = {5'd0, mq, 4'd0};
  assign cc_inc   = (cc_r == 8'hFF) ? cc_r : cc_r + 8'd1;
  assign cool_inc = (cool_r == 10'h3FF) ? cool_r : cool_r + 10'd1;

  assign mul_req.go  = mgo_r;
  assign mul_req.rnd = mrnd_r;
  assign mul_req.a   = ma_r;
  assign mul_req.b   = mb_r;
  assign sqrt_req.go = sgo_r;
  assign sqrt_req.n  = sum_r;

  mbcg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  mbcg_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  always_comb begin
    mbcg_pkg::gate_t g;
    logic [7:0]      c;
    logic [9:0]      k;
    logic            acc;
    logic            left;
    state_nxt  = state_r;
    gate_nxt   = gate_r;
    base_nxt   = base_r;
    dev_nxt    = dev_r;
    seeded_nxt = seeded_r;
    cc_nxt     = cc_r;
    cool_nxt   = cool_r;
    item_nxt   = item_r;
    axis_nxt   = axis_r;
    sum_nxt    = sum_r;
    mag_nxt    = mag_r;
    up_nxt     = up_r;
    ad_nxt     = ad_r;
    thr_nxt    = thr_r;
    res_nxt    = res_r;
    mgo_nxt    = 1'b0;
    mrnd_nxt   = mrnd_r;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    sgo_nxt    = 1'b0;
    res_valid  = 1'b0;
    g          = gate_r;
    c          = cc_r;
    k          = cool_r;
    acc        = 1'b0;
    left       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_item;
          if (in_item.restart) begin
            gate_nxt   = mbcg_pkg::GATE_IDLE;
            seeded_nxt = 1'b0;
            cc_nxt     = 8'd0;
            cool_nxt   = 10'd0;
            res_nxt    = '0;
            state_nxt  = S_OUT;
          end else begin
            axis_nxt  = 2'd0;
            sum_nxt   = 32'd0;
            mgo_nxt   = 1'b1;
            mrnd_nxt  = 1'b0;
            ma_nxt    = {16'd0, abs16(in_item.gyro_x)};
            mb_nxt    = abs16(in_item.gyro_x);
            state_nxt = S_SQ;
          end
        end
      end
      S_SQ: begin
        if (mul_rsp.done) begin
          sum_nxt = sum_r + mul_rsp.p[31:0];
          if (axis_r == 2'd2) begin
            sgo_nxt   = 1'b1;
            state_nxt = S_ROOT;
          end else begin
            axis_nxt = axis_r + 2'd1;
            mgo_nxt  = 1'b1;
            if (axis_r == 2'd0) begin
              ma_nxt = {16'd0, abs16(item_r.gyro_y)};
              mb_nxt = abs16(item_r.gyro_y);
            end else begin
              ma_nxt = {16'd0, abs16(item_r.gyro_z)};
              mb_nxt = abs16(item_r.gyro_z);
            end
          end
        end
      end
      S_ROOT: begin
        if (sqrt_rsp.done) begin
          mag_nxt = sqrt_rsp.root;
          unique case (gate_r)
            mbcg_pkg::GATE_IDLE: begin
              if (!seeded_r) begin
                // first sample after reset or restart seeds the tracker
                base_nxt   = mq_root;
                dev_nxt    = 32'd0;
                seeded_nxt = 1'b1;
                mgo_nxt    = 1'b1;
                mrnd_nxt   = 1'b0;
                ma_nxt     = 32'd0;
                mb_nxt     = {8'd0, cfg.onset_gain};
                state_nxt  = S_GAIN;
              end else begin
                up_nxt    = mq_root >= base_r;
                ma_nxt    = (mq_root >= base_r) ? mq_root - base_r : base_r - mq_root;
                mb_nxt    = cfg.ema_weight;
                mrnd_nxt  = 1'b1;
                mgo_nxt   = 1'b1;
                state_nxt = S_BEMA;
              end
            end
            mbcg_pkg::GATE_COOLDOWN: begin
              mgo_nxt   = 1'b1;
              mrnd_nxt  = 1'b0;
              ma_nxt    = dev_r;
              mb_nxt    = {8'd0, cfg.offset_gain};
              state_nxt = S_GAIN;
            end
            mbcg_pkg::GATE_ARMED,
            mbcg_pkg::GATE_CAPTURE: begin
              state_nxt = S_DECIDE;
            end
          endcase
        end
      end
      S_BEMA: begin
        if (mul_rsp.done) begin
          base_nxt  = ema_apply(base_r, step, up_r);
          state_nxt = S_AD;
        end
      end
      S_AD: begin
        // deviation target uses the updated baseline
        ad_nxt    = (mq >= base_r) ? mq - base_r : base_r - mq;
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        up_nxt    = ad_r >= dev_r;
        ma_nxt    = (ad_r >= dev_r) ? ad_r - dev_r : dev_r - ad_r;
        mb_nxt    = cfg.ema_weight;
        mrnd_nxt  = 1'b1;
        mgo_nxt   = 1'b1;
        state_nxt = S_DEMA;
      end
      S_DEMA: begin
        if (mul_rsp.done) begin
          dev_nxt   = ema_apply(dev_r, step, up_r);
          state_nxt = S_FLOOR;
        end
      end
      S_FLOOR: begin
        if (dev_r < cfg.deviation_floor) begin
          dev_nxt = cfg.deviation_floor;
          ma_nxt  = cfg.deviation_floor;
        end else begin
          ma_nxt  = dev_r;
        end
        mb_nxt    = {8'd0, cfg.onset_gain};
        mrnd_nxt  = 1'b0;
        mgo_nxt   = 1'b1;
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        if (mul_rsp.done) begin
          thr_nxt   = {5'd0, base_r, 4'd0} + {1'b0, mul_rsp.p[39:0]};
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (gate_r)
          mbcg_pkg::GATE_IDLE: begin
            if (lhs > thr_r) begin
              c = cc_inc;
              if (c >= {4'd0, cfg.onset_confirm}) begin
                c = 8'd0;
                g = mbcg_pkg::GATE_ARMED;
              end
            end else begin
              c = 8'd0;
            end
          end
          mbcg_pkg::GATE_ARMED: begin
            c = cc_inc;
            if (c >= cfg.capture_delay) begin
              c = 8'd0;
              g = mbcg_pkg::GATE_CAPTURE;
            end
          end
          mbcg_pkg::GATE_CAPTURE: begin
            c = cc_r;
          end
          mbcg_pkg::GATE_COOLDOWN: begin
            if (lhs >= thr_r) begin
              c = 8'd0;
            end else begin
              c = cc_inc;
              if (c >= {4'd0, cfg.settle_confirm}) begin
                c    = 8'd0;
                g    = mbcg_pkg::GATE_IDLE;
                left = 1'b1;
              end
            end
            // settled exit skips the cooldown tick
            if (!left) begin
              k = cool_inc;
              if (k >= cfg.cooldown_limit) begin
                c = 8'd0;
                g = mbcg_pkg::GATE_IDLE;
              end
            end
          end
        endcase
        if (item_r.window_done && g == mbcg_pkg::GATE_CAPTURE) begin
          acc = 1'b1;
          g   = mbcg_pkg::GATE_COOLDOWN;
          k   = 10'd0;
        end
        gate_nxt           = g;
        cc_nxt             = c;
        cool_nxt           = k;
        res_nxt.accept     = acc;
        res_nxt.gate_state = g;
        res_nxt.magnitude  = mag_r;
        state_nxt          = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      gate_r   <= mbcg_pkg::GATE_IDLE;
      base_r   <= 32'd0;
      dev_r    <= 32'd0;
      seeded_r <= 1'b0;
      cc_r     <= 8'd0;
      cool_r   <= 10'd0;
      mgo_r    <= 1'b0;
      sgo_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      gate_r   <= gate_nxt;
      base_r   <= base_nxt;
      dev_r    <= dev_nxt;
      seeded_r <= seeded_nxt;
      cc_r     <= cc_nxt;
      cool_r   <= cool_nxt;
      mgo_r    <= mgo_nxt;
      sgo_r    <= sgo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    axis_r <= axis_nxt;
    sum_r  <= sum_nxt;
    mag_r  <= mag_nxt;
    up_r   <= up_nxt;
    ad_r   <= ad_nxt;
    thr_r  <= thr_nxt;
    res_r  <= res_nxt;
    mrnd_r <= mrnd_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
  end

  assign ready = (state_r == S_IDLE);
  assign res   = res_r;

endmodule

### hw/rtl/motion_burst_capture_gate_core.sv
// motion_burst_capture_gate_core: top level of the motion onset capture gate
// depends on mbcg_pkg, mbcg_seq (which holds mbcg_mul and mbcg_isqrt)
//
// input channel: in_valid / in_stall / in_data, one gyro sample per beat.
// result channel: out_valid / out_stall / out_data, exactly one beat per sample.
// config: apb-style write/read port, register i at byte address 4*i, pready tied high;
//   write only while the block is idle.
// one sample is in flight at a time; in_stall is high from acceptance until its
// result is loaded into the output register. the output register lets the next
// sample be taken while a result still waits downstream.
// steps per sample: three squares on the shared multiplier, the serial root, then
// in idle once seeded the baseline and deviation averages and the threshold product;
// the seed sample and cooldown skip the averages, armed and capture go straight to
// the decision, a restart beat goes straight out; in_stall falls as out_valid rises.
// a stalled receiver holds the result in place and the block waits before
// loading the next one.
// reset (rst_n low, synchronous) restores the default registers and clears the gate,
// baseline, deviation, counters and both channels.
module motion_burst_capture_gate_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mbcg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mbcg_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  mbcg_pkg::cfg_t      cfg_r;
  logic                out_valid_r;
  mbcg_pkg::out_item_t out_data_r;
  logic                seq_ready;
  logic                seq_res_valid;
  mbcg_pkg::out_item_t seq_res;
  logic                out_free;
  logic                cfg_wr;
  logic [2:0]          reg_idx;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[4:2];
  assign cfg_wr   = psel && penable && pwrite;
  assign in_stall = !seq_ready;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ema_weight      <= mbcg_pkg::RST_EMA_WEIGHT;
      cfg_r.deviation_floor <= mbcg_pkg::RST_DEVIATION_FLOOR;
      cfg_r.onset_gain      <= mbcg_pkg::RST_ONSET_GAIN;
      cfg_r.offset_gain     <= mbcg_pkg::RST_OFFSET_GAIN;
      cfg_r.onset_confirm   <= mbcg_pkg::RST_ONSET_CONFIRM;
      cfg_r.settle_confirm  <= mbcg_pkg::RST_SETTLE_CONFIRM;
      cfg_r.capture_delay   <= mbcg_pkg::RST_CAPTURE_DELAY;
      cfg_r.cooldown_limit  <= mbcg_pkg::RST_COOLDOWN_LIMIT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        mbcg_pkg::REG_EMA_WEIGHT:      cfg_r.ema_weight      <= pwdata[15:0];
        mbcg_pkg::REG_DEVIATION_FLOOR: cfg_r.deviation_floor <= pwdata;
        mbcg_pkg::REG_ONSET_GAIN:      cfg_r.onset_gain      <= pwdata[7:0];
        mbcg_pkg::REG_OFFSET_GAIN:     cfg_r.offset_gain     <= pwdata[7:0];
        mbcg_pkg::REG_ONSET_CONFIRM:   cfg_r.onset_confirm   <= pwdata[3:0];
        mbcg_pkg::REG_SETTLE_CONFIRM:  cfg_r.settle_confirm  <= pwdata[3:0];
        mbcg_pkg::REG_CAPTURE_DELAY:   cfg_r.capture_delay   <= pwdata[7:0];
        mbcg_pkg::REG_COOLDOWN_LIMIT:  cfg_r.cooldown_limit  <= pwdata[9:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mbcg_pkg::REG_EMA_WEIGHT:      prdata = {16'd0, cfg_r.ema_weight};
      mbcg_pkg::REG_DEVIATION_FLOOR: prdata = cfg_r.deviation_floor;
      mbcg_pkg::REG_ONSET_GAIN:      prdata = {24'd0, cfg_r.onset_gain};
      mbcg_pkg::REG_OFFSET_GAIN:     prdata = {24'd0, cfg_r.offset_gain};
      mbcg_pkg::REG_ONSET_CONFIRM:   prdata = {28'd0, cfg_r.onset_confirm};
      mbcg_pkg::REG_SETTLE_CONFIRM:  prdata = {28'd0, cfg_r.settle_confirm};
      mbcg_pkg::REG_CAPTURE_DELAY:   prdata = {24'd0, cfg_r.capture_delay};
      mbcg_pkg::REG_COOLDOWN_LIMIT:  prdata = {22'd0, cfg_r.cooldown_limit};
    endcase
  end

  mbcg_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_item   (in_data),
    .ready     (seq_ready),
    .out_free  (out_free),
    .res_valid (seq_res_valid),
    .res       (seq_res)
  );

  // output register: loaded only when empty or draining this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_res_valid) begin
      out_data_r <= seq_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one sample at a time: an accepted beat blocks the next edge
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a sample is still in flight");

  // a result never overwrites one that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    seq_res_valid |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a stalled beat");

  // an accepted window always leaves the gate in cooldown
  a_accept_cooldown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accept |-> out_data.gate_state == mbcg_pkg::GATE_COOLDOWN)
    else $error("accept flagged outside cooldown");

endmodule
